FILE: sv/vcnd_pkg.sv
// ----------------------------------------------------------------------------
// vcnd_pkg
// Shared widths, command codes and the sideband record that travels with each
// vector through the normalize pipeline.
// ----------------------------------------------------------------------------
package vcnd_pkg;

    localparam int IN_W   = 24;   // Q8.16 input component
    localparam int PROD_W = 48;   // product of two input components
    localparam int MAG_W  = 49;   // magnitude of a cross product component
    localparam int SQ_W   = 98;   // sum of three squared magnitudes
    localparam int ROOT_W = 50;   // floor square root of the sum
    localparam int DOT_W  = 49;   // dot product field
    localparam int RES_W  = 18;   // unit vector component field
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CROSS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NORM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DOT   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]            cmd;
        logic [2:0]                  neg;
        logic [2:0][MAG_W-1:0]       mag;
        logic [DOT_W-1:0]            dot;
    } t_side;

endpackage

FILE: sv/vcnd_front.sv
// ----------------------------------------------------------------------------
// vcnd_front
// Five register stages: component products, cross product or copy of a and the
// dot product, split squares, per-component squares, and the sum of squares.
// ----------------------------------------------------------------------------
module vcnd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  logic [vcnd_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [vcnd_pkg::IN_W-1:0]    i_a_x,
    input  logic signed [vcnd_pkg::IN_W-1:0]    i_a_y,
    input  logic signed [vcnd_pkg::IN_W-1:0]    i_a_z,
    input  logic signed [vcnd_pkg::IN_W-1:0]    i_b_x,
    input  logic signed [vcnd_pkg::IN_W-1:0]    i_b_y,
    input  logic signed [vcnd_pkg::IN_W-1:0]    i_b_z,
    output logic                                o_vld,
    output logic [vcnd_pkg::SQ_W-1:0]           o_sum,
    output vcnd_pkg::t_side                     o_side
);

    localparam int PW = vcnd_pkg::PROD_W;
    localparam int MW = vcnd_pkg::MAG_W;
    localparam int SW = vcnd_pkg::SQ_W;
    localparam int LO_W = 25;           // low part of a magnitude
    localparam int HI_W = MW - LO_W;    // high part of a magnitude

    logic [4:0] r_vld;

    // Stage 1: nine products.
    logic [vcnd_pkg::CMD_W-1:0]        r1_cmd;
    logic signed [vcnd_pkg::IN_W-1:0]  r1_ax, r1_ay, r1_az;
    logic signed [PW-1:0]              r1_yz, r1_zy, r1_zx, r1_xz, r1_xy, r1_yx;
    logic signed [PW-1:0]              r1_dx, r1_dy, r1_dz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd <= i_cmd;
            r1_ax  <= i_a_x;
            r1_ay  <= i_a_y;
            r1_az  <= i_a_z;
            r1_yz  <= i_a_y * i_b_z;
            r1_zy  <= i_a_z * i_b_y;
            r1_zx  <= i_a_z * i_b_x;
            r1_xz  <= i_a_x * i_b_z;
            r1_xy  <= i_a_x * i_b_y;
            r1_yx  <= i_a_y * i_b_x;
            r1_dx  <= i_a_x * i_b_x;
            r1_dy  <= i_a_y * i_b_y;
            r1_dz  <= i_a_z * i_b_z;
        end
    end

    // Stage 2: the vector to normalize as sign and magnitude, and the dot product.
    logic signed [MW-1:0] n2_c [3];
    vcnd_pkg::t_side      n2_side;
    vcnd_pkg::t_side      r2_side;

    always_comb begin
        case (r1_cmd)
            vcnd_pkg::CMD_CROSS: begin
                n2_c[0] = MW'(r1_yz) - MW'(r1_zy);
                n2_c[1] = MW'(r1_zx) - MW'(r1_xz);
                n2_c[2] = MW'(r1_xy) - MW'(r1_yx);
            end
            vcnd_pkg::CMD_NORM: begin
                n2_c[0] = MW'(r1_ax);
                n2_c[1] = MW'(r1_ay);
                n2_c[2] = MW'(r1_az);
            end
            default: begin
                n2_c[0] = '0;
                n2_c[1] = '0;
                n2_c[2] = '0;
            end
        endcase
        n2_side.cmd = r1_cmd;
        for (int k = 0; k < 3; k++) begin
            n2_side.neg[k] = n2_c[k][MW-1];
            n2_side.mag[k] = n2_c[k][MW-1] ? MW'(-n2_c[k]) : MW'(n2_c[k]);
        end
        n2_side.dot = vcnd_pkg::DOT_W'(MW'(r1_dx) + MW'(r1_dy) + MW'(r1_dz));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= n2_side;
        end
    end

    // Stage 3: squares split into partial products of at most 25 bits a side.
    logic [2*HI_W-1:0]       r3_hh [3];
    logic [HI_W+LO_W-1:0]    r3_hl [3];
    logic [2*LO_W-1:0]       r3_ll [3];
    vcnd_pkg::t_side         r3_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side <= r2_side;
            for (int k = 0; k < 3; k++) begin
                r3_hh[k] <= r2_side.mag[k][MW-1:LO_W] * r2_side.mag[k][MW-1:LO_W];
                r3_hl[k] <= r2_side.mag[k][MW-1:LO_W] * r2_side.mag[k][LO_W-1:0];
                r3_ll[k] <= r2_side.mag[k][LO_W-1:0] * r2_side.mag[k][LO_W-1:0];
            end
        end
    end

    // Stage 4: each square; the cross term appears twice, hence the extra shift.
    logic [SW-1:0]   r4_sq [3];
    vcnd_pkg::t_side r4_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side <= r3_side;
            for (int k = 0; k < 3; k++) begin
                r4_sq[k] <= (SW'(r3_hh[k]) << (2 * LO_W)) + (SW'(r3_hl[k]) << (LO_W + 1))
                          + SW'(r3_ll[k]);
            end
        end
    end

    // Stage 5: sum of squares.
    logic [SW-1:0]   r5_sum;
    vcnd_pkg::t_side r5_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_side <= r4_side;
            r5_sum  <= r4_sq[0] + r4_sq[1] + r4_sq[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    assign o_vld  = r_vld[4];
    assign o_sum  = r5_sum;
    assign o_side = r5_side;

endmodule

FILE: sv/vcnd_sqrt.sv
// ----------------------------------------------------------------------------
// vcnd_sqrt
// Pipelined restoring square root: one root bit per register stage, keeping
// the remainder of the sum minus the square of the partial root.
// ----------------------------------------------------------------------------
module vcnd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [vcnd_pkg::SQ_W-1:0]     i_sum,
    input  vcnd_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [vcnd_pkg::ROOT_W-1:0]   o_root,
    output vcnd_pkg::t_side               o_side
);

    localparam int N  = vcnd_pkg::ROOT_W;
    localparam int SW = vcnd_pkg::SQ_W;
    localparam int TW = SW + 3;

    logic            s_vld  [0:N];
    logic [SW-1:0]   s_rem  [0:N];
    logic [N-1:0]    s_root [0:N];
    vcnd_pkg::t_side s_side [0:N];

    logic            r_vld  [0:N-1];
    logic [SW-1:0]   r_rem  [0:N-1];
    logic [N-1:0]    r_root [0:N-1];
    vcnd_pkg::t_side r_side [0:N-1];

    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = i_sum;
    assign s_root[0] = '0;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int B = N - 1 - k;

        logic [TW-1:0] trial;
        logic          take;
        logic [SW-1:0] n_rem;
        logic [N-1:0]  n_root;

        // (r + 2^B)^2 - r^2, with r holding only bits above B.
        always_comb begin
            trial  = (TW'(s_root[k]) << (B + 1)) | (TW'(1) << (2 * B));
            take   = TW'(s_rem[k]) >= trial;
            n_rem  = take ? SW'(TW'(s_rem[k]) - trial) : s_rem[k];
            n_root = take ? (s_root[k] | (N'(1) << B)) : s_root[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= s_side[k];
            end
        end

        assign s_vld[k+1]  = r_vld[k];
        assign s_rem[k+1]  = r_rem[k];
        assign s_root[k+1] = r_root[k];
        assign s_side[k+1] = r_side[k];
    end

    assign o_vld  = s_vld[N];
    assign o_root = s_root[N];
    assign o_side = s_side[N];

`ifndef SYNTH
    // A finished root leaves a remainder no larger than twice the root.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_vld[N] |-> (TW'(s_rem[N]) <= (TW'(s_root[N]) << 1)))
        else $error("square root remainder out of range");
`endif

endmodule

FILE: sv/vcnd_div.sv
// ----------------------------------------------------------------------------
// vcnd_div
// Three-lane pipelined restoring divider: magnitude times 2^FRAC_BITS over the
// root, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module vcnd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic [vcnd_pkg::ROOT_W-1:0]          i_d,
    input  vcnd_pkg::t_side                      i_side,
    output logic                                 o_vld,
    output logic [vcnd_pkg::ROOT_W-1:0]          o_d,
    output logic [2:0][FRAC_BITS:0]              o_q,
    output vcnd_pkg::t_side                      o_side
);

    localparam int ND = FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 1;
    localparam int RW = vcnd_pkg::ROOT_W;

    logic                     r_vld  [0:ND-1];
    logic [RW-1:0]            r_d    [0:ND-1];
    logic [2:0][RW-1:0]       r_rem  [0:ND-1];
    logic [2:0][QW-1:0]       r_q    [0:ND-1];
    vcnd_pkg::t_side          r_side [0:ND-1];

    for (genvar k = 0; k < ND; k++) begin : g_stage
        logic [2:0][RW-1:0] n_rem;
        logic [2:0][QW-1:0] n_q;
        logic [2:0]         ge;

        if (k == 0) begin : g_first
            // Integer part: the magnitude never exceeds the root, so one bit.
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    ge[l]    = RW'(i_side.mag[l]) >= i_d;
                    n_rem[l] = RW'(i_side.mag[l]) - (ge[l] ? i_d : RW'(0));
                    n_q[l]   = QW'(ge[l]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= i_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[k]    <= i_d;
                    r_rem[k]  <= n_rem;
                    r_q[k]    <= n_q;
                    r_side[k] <= i_side;
                end
            end
        end else begin : g_step
            logic [RW:0] two [3];

            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    two[l]   = {r_rem[k-1][l], 1'b0};
                    ge[l]    = two[l] >= {1'b0, r_d[k-1]};
                    n_rem[l] = ge[l] ? RW'(two[l] - {1'b0, r_d[k-1]}) : RW'(two[l]);
                    n_q[l]   = {r_q[k-1][l][QW-2:0], ge[l]};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[k]    <= r_d[k-1];
                    r_rem[k]  <= n_rem;
                    r_q[k]    <= n_q;
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_vld  = r_vld[ND-1];
    assign o_d    = r_d[ND-1];
    assign o_q    = r_q[ND-1];
    assign o_side = r_side[ND-1];

`ifndef SYNTH
    // Every lane ends with a remainder below a nonzero divisor.
    a_rem_lt_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ND-1] && (r_d[ND-1] != '0)) |->
        ((r_rem[ND-1][0] < r_d[ND-1]) && (r_rem[ND-1][1] < r_d[ND-1])
         && (r_rem[ND-1][2] < r_d[ND-1])))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: sv/vector3_cross_normalize_dot.sv
// Throughput: one request per cycle while the output is not stalled; five front stages,
// one square root stage per root bit, one divider stage per quotient bit and the output
// register make up the depth.
// A stalled output holds the whole pipeline, so no request is lost or repeated.
// Reset (i_rst_n low at a clock edge) clears all valid bits; data registers keep values.
// ----------------------------------------------------------------------------
// vector3_cross_normalize_dot
// Normalized cross product, normalized vector a, or exact dot product of two
// Q8.16 vectors, selected per request.
// ----------------------------------------------------------------------------
module vector3_cross_normalize_dot #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [143:0]  i_s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
    input  logic [1:0]    i_s_axis_tuser,   // cmd
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [103:0]  o_m_axis_tdata,   // res_x, res_y, res_z, dot_value, zero pad
    output logic          o_m_axis_tuser    // zero_length
);

    localparam int IW = vcnd_pkg::IN_W;
    localparam int QW = FRAC_BITS + 1;
    localparam int RES_W = vcnd_pkg::RES_W;
    localparam int EW = (QW + 1 > RES_W) ? QW + 1 : RES_W;
    localparam logic [QW-1:0] LIM = QW'(1) << FRAC_BITS;

    logic en;
    logic r_out_vld;

    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    logic                 f_vld;
    logic [vcnd_pkg::SQ_W-1:0] f_sum;
    vcnd_pkg::t_side      f_side;

    vcnd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_axis_tvalid),
        .i_cmd   (i_s_axis_tuser),
        .i_a_x   ($signed(i_s_axis_tdata[IW-1:0])),
        .i_a_y   ($signed(i_s_axis_tdata[2*IW-1:IW])),
        .i_a_z   ($signed(i_s_axis_tdata[3*IW-1:2*IW])),
        .i_b_x   ($signed(i_s_axis_tdata[4*IW-1:3*IW])),
        .i_b_y   ($signed(i_s_axis_tdata[5*IW-1:4*IW])),
        .i_b_z   ($signed(i_s_axis_tdata[6*IW-1:5*IW])),
        .o_vld   (f_vld),
        .o_sum   (f_sum),
        .o_side  (f_side)
    );

    logic                        s_vld;
    logic [vcnd_pkg::ROOT_W-1:0] s_root;
    vcnd_pkg::t_side             s_side;

    vcnd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_sum   (f_sum),
        .i_side  (f_side),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    logic                        d_vld;
    logic [vcnd_pkg::ROOT_W-1:0] d_d;
    logic [2:0][QW-1:0]          d_q;
    vcnd_pkg::t_side             d_side;

    vcnd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_d     (s_root),
        .i_side  (s_side),
        .o_vld   (d_vld),
        .o_d     (d_d),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    // Output stage: clamp, restore the sign, and select by command.
    logic                 is_unit;
    logic                 n_zl;
    logic [QW-1:0]        qc [3];
    logic signed [EW-1:0] sv [3];
    logic [RES_W-1:0]     n_res [3];
    logic [vcnd_pkg::DOT_W-1:0] n_dot;
    logic [103:0]         r_out_data;
    logic                 r_out_user;

    always_comb begin
        is_unit = (d_side.cmd == vcnd_pkg::CMD_CROSS) || (d_side.cmd == vcnd_pkg::CMD_NORM);
        n_zl    = is_unit && (d_d == '0);
        for (int l = 0; l < 3; l++) begin
            qc[l]    = (d_q[l] > LIM) ? LIM : d_q[l];
            sv[l]    = d_side.neg[l] ? -$signed(EW'(qc[l])) : $signed(EW'(qc[l]));
            n_res[l] = (is_unit && !n_zl) ? sv[l][RES_W-1:0] : '0;
        end
        n_dot = (d_side.cmd == vcnd_pkg::CMD_DOT) ? d_side.dot : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {1'b0, n_dot, n_res[2], n_res[1], n_res[0]};
            r_out_user <= n_zl;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTH
    // A zero-length vector never carries a unit vector.
    a_zl_zero_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[53:0] == '0))
        else $error("zero length result with nonzero components");

    // The dot product and the zero-length flag belong to different commands.
    a_dot_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[102:54] != '0)) |->
        (!o_m_axis_tuser && (o_m_axis_tdata[53:0] == '0)))
        else $error("dot product mixed with unit vector result");

    // The pipeline only holds back requests while a result waits downstream.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output backpressure");
`endif

endmodule
